@@ hdl/fdsd_pkg.sv @@
package fdsd_pkg;

  localparam logic [7:0]  MARKER_RESET = 8'h10;
  localparam logic [15:0] ESCAPE_WORD  = 16'h8000;

  typedef enum logic [3:0] {
    PH_MARK  = 4'd0,
    PH_COUNT = 4'd1,
    PH_DHI   = 4'd2,
    PH_DLO   = 4'd3,
    PH_ESC0  = 4'd4,
    PH_ESC1  = 4'd5,
    PH_ESC2  = 4'd6,
    PH_ESC3  = 4'd7,
    PH_STOP  = 4'd8
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic               sample_valid;
    logic signed [31:0] sample_value;
    logic               stream_done;
    logic               truncated;
  } out_item_t;

endpackage

@@ hdl/framed_delta_signal_decoder_core.sv @@
// Framed delta signal decoder: one body byte per beat in, at most one sample beat out.
// A result is registered in the result register, or in the skid register under stall.
// Throughput: one input beat per cycle while the skid entry is empty; the decode state
// updates in a single pass. The two output entries are the result and skid registers.
// Reset (rst, synchronous, active high) empties both output entries, returns the decoder to
// expecting a block marker with a zero running value, and sets block_marker to 16.
module framed_delta_signal_decoder_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic [7:0]            cfg_write_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  fdsd_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output fdsd_pkg::out_item_t   out_data
);

  // Configuration: byte that must open every delta block.
  logic [7:0] block_marker;

  // Decode state.
  fdsd_pkg::phase_t phase, phase_next;
  logic [7:0]       deltas_left, deltas_left_next;
  logic [31:0]      running_value, running_value_next;
  logic [7:0]       high_byte_hold, high_byte_hold_next;
  logic [23:0]      escape_bytes, escape_bytes_next;

  // Output side: result register and skid register.
  logic                skid_valid;
  fdsd_pkg::out_item_t skid_data;

  logic                in_accept;
  logic                has_result;
  fdsd_pkg::out_item_t result;
  logic                out_free;

  logic [15:0]      word;
  logic [31:0]      delta_ext;
  fdsd_pkg::phase_t phase_step;
  logic             sample_done;

  // Stall the input only when the skid entry is holding a beat.
  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign word      = {high_byte_hold, in_data.data_byte};
  assign delta_ext = {{16{word[15]}}, word};

  // Single-pass decode of one byte.
  always_comb begin
    phase_step          = phase;
    deltas_left_next    = deltas_left;
    running_value_next  = running_value;
    high_byte_hold_next = high_byte_hold;
    escape_bytes_next   = escape_bytes;
    sample_done         = 1'b0;

    unique case (phase)
      fdsd_pkg::PH_MARK: begin
        phase_step = (in_data.data_byte == block_marker) ? fdsd_pkg::PH_COUNT
                                                         : fdsd_pkg::PH_STOP;
      end
      fdsd_pkg::PH_COUNT: begin
        if (in_data.data_byte == 8'd0) begin
          phase_step = fdsd_pkg::PH_STOP;
        end else begin
          deltas_left_next = in_data.data_byte;
          phase_step       = fdsd_pkg::PH_DHI;
        end
      end
      fdsd_pkg::PH_DHI: begin
        high_byte_hold_next = in_data.data_byte;
        phase_step          = fdsd_pkg::PH_DLO;
      end
      fdsd_pkg::PH_DLO: begin
        if (word == fdsd_pkg::ESCAPE_WORD) begin
          escape_bytes_next = 24'd0;
          phase_step        = fdsd_pkg::PH_ESC0;
        end else begin
          running_value_next = running_value + delta_ext;
          sample_done        = 1'b1;
        end
      end
      fdsd_pkg::PH_ESC0: begin
        escape_bytes_next = {escape_bytes[15:0], in_data.data_byte};
        phase_step        = fdsd_pkg::PH_ESC1;
      end
      fdsd_pkg::PH_ESC1: begin
        escape_bytes_next = {escape_bytes[15:0], in_data.data_byte};
        phase_step        = fdsd_pkg::PH_ESC2;
      end
      fdsd_pkg::PH_ESC2: begin
        escape_bytes_next = {escape_bytes[15:0], in_data.data_byte};
        phase_step        = fdsd_pkg::PH_ESC3;
      end
      fdsd_pkg::PH_ESC3: begin
        running_value_next = {escape_bytes, in_data.data_byte};
        sample_done        = 1'b1;
      end
      default: begin
        phase_step = fdsd_pkg::PH_STOP;
      end
    endcase

    // Count down a finished delta; return to marker when the block is spent.
    if (sample_done) begin
      deltas_left_next = deltas_left - 8'd1;
      phase_step = (deltas_left_next == 8'd0) ? fdsd_pkg::PH_MARK : fdsd_pkg::PH_DHI;
    end

    result.sample_valid = sample_done;
    result.sample_value = sample_done ? running_value_next : 32'sd0;
    result.stream_done  = in_data.end_of_stream;
    result.truncated    = in_data.end_of_stream &&
                          (phase_step == fdsd_pkg::PH_DHI  ||
                           phase_step == fdsd_pkg::PH_DLO  ||
                           phase_step == fdsd_pkg::PH_ESC0 ||
                           phase_step == fdsd_pkg::PH_ESC1 ||
                           phase_step == fdsd_pkg::PH_ESC2 ||
                           phase_step == fdsd_pkg::PH_ESC3);
    has_result = sample_done || in_data.end_of_stream;

    // The final byte of a stream drops all decode state back to reset values.
    phase_next = phase_step;
    if (in_data.end_of_stream) begin
      phase_next          = fdsd_pkg::PH_MARK;
      deltas_left_next    = 8'd0;
      running_value_next  = 32'd0;
      high_byte_hold_next = 8'd0;
      escape_bytes_next   = 24'd0;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_marker <= fdsd_pkg::MARKER_RESET;
    end else if (cfg_write_en) begin
      block_marker <= cfg_write_data;
    end
  end

  // Decode state: advance only on an accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= fdsd_pkg::PH_MARK;
      deltas_left    <= 8'd0;
      running_value  <= 32'd0;
      high_byte_hold <= 8'd0;
      escape_bytes   <= 24'd0;
    end else if (in_accept) begin
      phase          <= phase_next;
      deltas_left    <= deltas_left_next;
      running_value  <= running_value_next;
      high_byte_hold <= high_byte_hold_next;
      escape_bytes   <= escape_bytes_next;
    end
  end

  // Output control: the result register takes the skid beat first, else the new result;
  // a new result that cannot reach the result register parks in the skid register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_accept && has_result;
      end
    end else if (in_accept && has_result) begin
      skid_valid <= 1'b1;
    end
  end

  // Output payload: no reset needed.
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= skid_valid ? skid_data : result;
    end else if (in_accept && has_result) begin
      skid_data <= result;
    end
  end

`ifndef NO_ASSERTIONS
  // A truncation flag only ever rides on the final beat of a stream.
  a_trunc_needs_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.truncated || out_data.stream_done))
    else $error("truncated without stream_done");

  // A beat without a sample carries a zero value.
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.sample_valid) |-> (out_data.sample_value == 32'sd0))
    else $error("sample_value nonzero without sample_valid");

  // The skid entry fills only while the result register is occupied.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a beat while the result register is empty");

  // An accepted end-of-stream byte leaves the decoder expecting a fresh marker.
  a_eos_restart: assert property (@(posedge clk) disable iff (rst)
    (in_accept && in_data.end_of_stream) |=>
      (phase == fdsd_pkg::PH_MARK && running_value == 32'd0))
    else $error("decoder not restarted after end of stream");
`endif

endmodule

@@ tb/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  localparam int RANDOM_BEATS = 550;
  localparam int HOLD_CYCLES  = 300;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_write_en;
  logic [7:0]          cfg_write_data;
  logic                in_valid;
  logic                in_stall;
  fdsd_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall = 1'b0;
  fdsd_pkg::out_item_t out_data;

  framed_delta_signal_decoder_core dut (
    .clk,
    .rst,
    .cfg_write_en,
    .cfg_write_data,
    .in_valid,
    .in_stall,
    .in_data,
    .out_valid,
    .out_stall,
    .out_data
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Decoder shadow state, advanced once per accepted input beat.
  fdsd_pkg::phase_t dec_phase;
  logic [7:0]       dec_marker;
  logic [7:0]       dec_left;
  logic [31:0]      dec_run;
  logic [7:0]       dec_hi;
  logic [23:0]      dec_esc;

  fdsd_pkg::out_item_t expected_samples[$];
  logic [7:0]          body_q[$];
  int                  errors = 0;
  int                  beat_count = 0;
  int                  burst_left = 0;

  // Receiver stall pattern and the long hold-off request.
  bit          hold_req = 1'b0;
  int          hold_cnt = 0;
  int          seg_left = 0;
  stall_mode_t stall_mode = STALL_NONE;

  task automatic clear_stream_state();
    dec_phase = fdsd_pkg::PH_MARK;
    dec_left  = '0;
    dec_run   = '0;
    dec_hi    = '0;
    dec_esc   = '0;
  endtask

  task automatic retire_delta();
    dec_left  = dec_left - 8'd1;
    dec_phase = (dec_left == 8'd0) ? fdsd_pkg::PH_MARK : fdsd_pkg::PH_DHI;
  endtask

  task automatic stage_byte(input logic [7:0] b);
    body_q = {body_q, b};
  endtask

  // Advance the shadow decoder by one byte; report the result beat it causes, if any.
  task automatic decode_byte(input fdsd_pkg::in_item_t it, output bit has_res,
                             output fdsd_pkg::out_item_t res);
    logic [15:0] word;
    bit          got;
    got = 1'b0;
    case (dec_phase)
      fdsd_pkg::PH_MARK: begin
        dec_phase = (it.data_byte == dec_marker) ? fdsd_pkg::PH_COUNT : fdsd_pkg::PH_STOP;
      end
      fdsd_pkg::PH_COUNT: begin
        if (it.data_byte == 8'd0) begin
          dec_phase = fdsd_pkg::PH_STOP;
        end else begin
          dec_left  = it.data_byte;
          dec_phase = fdsd_pkg::PH_DHI;
        end
      end
      fdsd_pkg::PH_DHI: begin
        dec_hi    = it.data_byte;
        dec_phase = fdsd_pkg::PH_DLO;
      end
      fdsd_pkg::PH_DLO: begin
        word = {dec_hi, it.data_byte};
        if (word == fdsd_pkg::ESCAPE_WORD) begin
          dec_esc   = '0;
          dec_phase = fdsd_pkg::PH_ESC0;
        end else begin
          dec_run = dec_run + {{16{word[15]}}, word};
          got     = 1'b1;
          retire_delta();
        end
      end
      fdsd_pkg::PH_ESC0, fdsd_pkg::PH_ESC1, fdsd_pkg::PH_ESC2: begin
        dec_esc   = {dec_esc[15:0], it.data_byte};
        dec_phase = fdsd_pkg::phase_t'(dec_phase + 4'd1);
      end
      fdsd_pkg::PH_ESC3: begin
        dec_run = {dec_esc, it.data_byte};
        got     = 1'b1;
        retire_delta();
      end
      default: dec_phase = fdsd_pkg::PH_STOP;
    endcase
    res.sample_valid = got;
    res.sample_value = got ? dec_run : 32'd0;
    res.stream_done  = it.end_of_stream;
    // Payload still pending when the stream closes means a cut-off block.
    res.truncated    = it.end_of_stream && (dec_phase >= fdsd_pkg::PH_DHI) &&
                       (dec_phase <= fdsd_pkg::PH_ESC3);
    has_res          = got || it.end_of_stream;
    if (it.end_of_stream) clear_stream_state();
  endtask

  // Offer one input beat, in bursts with random gaps, and hold it until accepted.
  task automatic send_beat(input fdsd_pkg::in_item_t it);
    bit                  has_res;
    fdsd_pkg::out_item_t res;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_byte(it, has_res, res);
    if (has_res) expected_samples = {expected_samples, res};
    burst_left--;
    beat_count++;
  endtask

  // Send the staged body, marking its last byte as end of stream.
  task automatic send_body();
    fdsd_pkg::in_item_t it;
    for (int i = 0; i < body_q.size(); i++) begin
      it.data_byte     = body_q[i];
      it.end_of_stream = (i == body_q.size() - 1);
      send_beat(it);
    end
    body_q.delete();
  endtask

  // Keep only the first n staged bytes.
  task automatic cut_body(input int n);
    if (body_q.size() > n) body_q = body_q[0:n-1];
  endtask

  task automatic add_delta(input logic [15:0] w);
    stage_byte(w[15:8]);
    stage_byte(w[7:0]);
  endtask

  task automatic add_escape(input logic [31:0] v);
    add_delta(fdsd_pkg::ESCAPE_WORD);
    stage_byte(v[31:24]);
    stage_byte(v[23:16]);
    stage_byte(v[15:8]);
    stage_byte(v[7:0]);
  endtask

  // Stage a well-formed block with random deltas, some escapes and some extremes.
  task automatic add_random_block(input logic [7:0] cnt);
    int          pick;
    logic [15:0] w;
    stage_byte(dec_marker);
    stage_byte(cnt);
    for (int k = 0; k < cnt; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        add_escape(pick < 3 ? 32'h8000_0000 : pick < 6 ? 32'h7FFF_FFFF : $urandom());
      end else if (pick < 25) begin
        case ($urandom_range(0, 4))
          0: add_delta(16'h7FFF);
          1: add_delta(16'h8001);
          2: add_delta(16'hFFFF);
          3: add_delta(16'h0000);
          default: add_delta(16'h0001);
        endcase
      end else begin
        w = 16'($urandom_range(0, 65535));
        // A random word that lands on the escape code must carry its value bytes.
        if (w == fdsd_pkg::ESCAPE_WORD) add_escape($urandom());
        else add_delta(w);
      end
    end
  endtask

  task automatic add_noise(input int n);
    repeat (n) stage_byte(8'($urandom_range(0, 255)));
  endtask

  // Drop valid and wait until every expected beat has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_marker(input logic [7:0] v);
    wait_drained();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    dec_marker = v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // Reset marker, escape with the largest value, wraparound, the most negative delta.
  task automatic test_directed_values();
    stage_byte(dec_marker);
    stage_byte(8'd4);
    add_escape(32'h7FFF_FFFF);
    add_delta(16'h7FFF);
    add_delta(16'h8001);
    add_delta(16'h0000);
    send_body();
  endtask

  task automatic test_stream_ends();
    // wrong marker: the rest is ignored, the final beat is a clean end
    stage_byte(dec_marker + 8'd1);
    stage_byte(8'h55);
    stage_byte(8'hAA);
    send_body();
    // zero count stops decoding
    stage_byte(dec_marker);
    stage_byte(8'h00);
    stage_byte(8'hFF);
    send_body();
    // end on the marker itself
    stage_byte(dec_marker);
    send_body();
    // end right after the count, deltas still owed
    stage_byte(dec_marker);
    stage_byte(8'h02);
    send_body();
    // end halfway through a delta
    stage_byte(dec_marker);
    stage_byte(8'h01);
    stage_byte(8'h12);
    send_body();
    // end inside an escape
    stage_byte(dec_marker);
    stage_byte(8'h01);
    add_delta(fdsd_pkg::ESCAPE_WORD);
    stage_byte(8'hAB);
    send_body();
  endtask

  task automatic test_marker_settings();
    write_marker(8'h00);
    stage_byte(8'h00);
    stage_byte(8'h01);
    add_delta(16'hFFFF);
    send_body();
    write_marker(8'hFF);
    stage_byte(8'hFF);
    stage_byte(8'h02);
    add_escape(32'h8000_0000);
    add_delta(16'h7FFF);
    send_body();
    // the reset marker no longer opens a block
    stage_byte(fdsd_pkg::MARKER_RESET);
    stage_byte(8'h01);
    add_delta(16'h1234);
    send_body();
  endtask

  // Hold the output for a long stretch while a long block keeps the sender busy.
  task automatic test_output_backpressure();
    hold_req = 1'b1;
    add_random_block(8'd60);
    send_body();
  endtask

  task automatic test_random_streams();
    int kind;
    int ending;
    int cnt;
    int streams;
    int target;
    bit big;
    streams = 0;
    target  = beat_count + RANDOM_BEATS;
    while (beat_count < target) begin
      if (streams % 12 == 11) write_marker(8'($urandom_range(0, 255)));
      streams++;
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        add_noise($urandom_range(1, 12));
      end else if (kind < 14) begin
        stage_byte(dec_marker ^ 8'($urandom_range(1, 255)));
        add_noise($urandom_range(0, 5));
      end else if (kind < 19) begin
        stage_byte(dec_marker);
        stage_byte(8'h00);
        add_noise($urandom_range(0, 5));
      end else begin
        big = 1'b0;
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 99) < 15) begin
            cnt = $urandom_range(1, 255);
            big = 1'b1;
          end else begin
            cnt = $urandom_range(1, 6);
          end
          add_random_block(8'(cnt));
        end
        ending = $urandom_range(0, 99);
        if (big) begin
          // keep long counts cheap: cut the body short
          cut_body($urandom_range(2, 48));
        end else if (ending < 25) begin
          cut_body($urandom_range(1, body_q.size()));
        end else if (ending < 35) begin
          stage_byte(dec_marker);
        end else if (ending < 45) begin
          stage_byte(dec_marker);
          stage_byte(8'($urandom_range(1, 255)));
        end
      end
      send_body();
    end
  endtask

  // Receiver: stall in segments of random mode and length, or hold off on request.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt--;
    end else begin
      if (seg_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        seg_left   = $urandom_range(16, 160);
      end
      seg_left--;
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= (seg_left % 3 == 0);
      endcase
    end
  end

  // Compare each accepted output beat with the oldest expected sample.
  always @(posedge clk) begin : check_samples
    fdsd_pkg::out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        errors++;
        $display("%0t unexpected beat: valid=%b value=%h done=%b trunc=%b", $time,
                 out_data.sample_valid, out_data.sample_value, out_data.stream_done,
                 out_data.truncated);
      end else begin
        want = expected_samples.pop_front();
        if (out_data !== want) begin
          errors++;
          $display({"%0t mismatch: expected valid=%b value=%h done=%b trunc=%b,",
                    " actual valid=%b value=%h done=%b trunc=%b"},
                   $time, want.sample_valid, want.sample_value, want.stream_done,
                   want.truncated, out_data.sample_valid, out_data.sample_value,
                   out_data.stream_done, out_data.truncated);
        end
      end
    end
  end

  initial begin
    rst            <= 1'b1;
    cfg_write_en   <= 1'b0;
    cfg_write_data <= '0;
    in_valid       <= 1'b0;
    in_data        <= '0;
    dec_marker = fdsd_pkg::MARKER_RESET;
    clear_stream_state();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_values();
    test_stream_ends();
    test_marker_settings();
    test_output_backpressure();
    test_random_streams();

    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0 && expected_samples.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ files.f @@
hdl/fdsd_pkg.sv
hdl/framed_delta_signal_decoder_core.sv
tb/tb.sv
